// File: rtl/svap_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svap_pkg
// shared types and constants for the seven-bit ascii pack/unpack block
// ----------------------------------------------------------------------------
package svap_pkg;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_COUNT = 2'd1;

   // mode register codes
   localparam logic MODE_PACK   = 1'b0;
   localparam logic MODE_UNPACK = 1'b1;

   // pending bits never exceed seven between items
   localparam int unsigned ACC_W  = 7;
   localparam int unsigned FILL_W = 3;

   typedef struct packed {
      logic [7:0] data_in;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       last_out;
      logic       error;
   } rsp_type;

   // one classified item: up to two result bytes
   typedef struct packed {
      logic [1:0] cnt;
      logic [7:0] val0;
      logic [7:0] val1;
      logic       last;
      logic       error;
   } work_type;

endpackage
`default_nettype wire

// File: rtl/seven_bit_ascii_pack_unpack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seven_bit_ascii_pack_unpack
// packs 7-bit characters into bytes, or unpacks bytes into 7-bit characters,
// selected by the mode register
// ----------------------------------------------------------------------------
//
//  channel  handshake              payload        direction
//  req_     req_push / req_full    req_data       into block, one byte per transfer
//  rsp_     rsp_empty / rsp_pop    rsp_data       out of block, one result per transfer
//  csr_     csr_valid / csr_ready  index, wdata   into block, register writes
//
//  one input transfer per cycle while req_full is low; the front updates the bit
//  accumulator in the cycle of the transfer and queues zero, one or two result bytes
//  results leave one per cycle through the output register while the consumer pops,
//  so an item with two results leaves as two; QUEUE_DEPTH records absorb the burst
//  a first result passes the queue record and then the output register before it shows
//  reset is synchronous and needs no clearing pass
//  req_full follows the work queue only; a stalled consumer backs up the
//  queue, after which input transfers stop
//
module seven_bit_ascii_pack_unpack #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire                                clock,
   input  wire                                reset,
   // input channel
   input  wire                                req_push,
   output logic                               req_full,
   input  svap_pkg::req_type                  req_data,
   // result channel
   output logic                               rsp_empty,
   input  wire                                rsp_pop,
   output svap_pkg::rsp_type                  rsp_data,
   // configuration channel
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [svap_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [31:0]                        csr_wdata
);

   logic                  accept;
   logic                  csr_write;
   logic                  work_push;
   svap_pkg::work_type    work_data;
   svap_pkg::work_type    head;
   logic                  queue_full;
   logic                  queue_empty;
   logic                  queue_pop;
   logic                  busy_split;

   // the user must write registers only while idle (the block does not enforce this), so writes are always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // input transfer whenever the work queue has room
   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   // front: accumulator, count and abort state, classifies each byte
   svap_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .work_push (work_push),
      .work_data (work_data)
   );

   // decoupling queue between front and back
   svap_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work_data),
      .pop       (queue_pop),
      .head      (head),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // back: one result per cycle into the output register while the consumer keeps popping
   svap_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .busy_split  (busy_split),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

   // error results are always a lone zero byte that closes its item
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.error) |-> (rsp_data.last_out && (rsp_data.data_out == 8'd0)))
      else $error("error result without last_out or with nonzero data");

   // a half-delivered two-byte record stays at the head of the queue
   assert property (@(posedge clock) disable iff (reset)
      busy_split |-> !queue_empty)
      else $error("split pending with empty work queue");

   // after reset nothing is waiting and the input side is open
   assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full && !busy_split))
      else $error("block not idle after reset");

   // a result that is not taken stays put and keeps the queue head pending
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("output register changed while stalled");

endmodule
`default_nettype wire

// File: rtl/svap_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svap_front
// takes input items, runs the bit accumulator and turns each item into a
// work record of zero, one or two result bytes
// ----------------------------------------------------------------------------
module svap_front (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  accept,
   input  svap_pkg::req_type                    req_data,
   input  wire                                  csr_write,
   input  wire  [svap_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [31:0]                          csr_wdata,
   output logic                                 work_push,
   output svap_pkg::work_type                   work_data
);

   logic                          mode_ff,    mode_in;
   logic [31:0]                   count_ff,   count_in;
   logic [31:0]                   left_ff,    left_in;
   logic [svap_pkg::ACC_W-1:0]    accum_ff,   accum_in;
   logic [svap_pkg::FILL_W-1:0]   fill_ff,    fill_in;
   logic                          aborted_ff, aborted_in;

   // pack path
   logic [15:0] p_acc;
   logic [3:0]  p_fill;
   logic        p_first;
   logic [15:0] p_rest;
   logic [3:0]  p_rest_fill;
   logic        p_tail;

   // unpack path
   logic [15:0] u_acc;
   logic [3:0]  u_fill;
   logic        u_two;
   logic        u_e1;
   logic        u_e2;
   logic [1:0]  u_cnt;
   logic [15:0] u_rest;
   logic [3:0]  u_rest_fill;

   logic        bad;

   always_comb begin
      p_acc       = {9'd0, accum_ff} | ({9'd0, req_data.data_in[6:0]} << fill_ff);
      p_fill      = {1'b0, fill_ff} + 4'd7;
      p_first     = (p_fill >= 4'd8);
      p_rest      = p_first ? (p_acc >> 8) : p_acc;
      p_rest_fill = p_first ? (p_fill - 4'd8) : p_fill;
      p_tail      = req_data.last_in && (p_rest_fill != 4'd0);

      u_acc       = {9'd0, accum_ff} | ({8'd0, req_data.data_in} << fill_ff);
      u_fill      = {1'b0, fill_ff} + 4'd8;
      u_two       = (u_fill >= 4'd14);
      u_e1        = (left_ff != 32'd0);
      u_e2        = u_two && (left_ff[31:1] != 31'd0);
      u_cnt       = u_e2 ? 2'd2 : (u_e1 ? 2'd1 : 2'd0);
      u_rest      = u_two ? (u_acc >> 14) : (u_acc >> 7);
      u_rest_fill = u_two ? (u_fill - 4'd14) : (u_fill - 4'd7);

      bad = aborted_ff || ((mode_ff == svap_pkg::MODE_PACK) && req_data.data_in[7]);
   end

   always_comb begin
      mode_in    = mode_ff;
      count_in   = count_ff;
      left_in    = left_ff;
      accum_in   = accum_ff;
      fill_in    = fill_ff;
      aborted_in = aborted_ff;
      work_data  = '0;

      if (bad) begin
         // aborted: one error result per item until reset
         work_data.cnt   = 2'd1;
         work_data.last  = 1'b1;
         work_data.error = 1'b1;
         if (accept) begin
            aborted_in = 1'b1;
         end
      end else if (mode_ff == svap_pkg::MODE_PACK) begin
         work_data.cnt  = {1'b0, p_first} + {1'b0, p_tail};
         work_data.val0 = p_acc[7:0];
         work_data.val1 = p_rest[7:0];
         work_data.last = req_data.last_in;
         if (accept) begin
            accum_in = req_data.last_in ? '0 : p_rest[svap_pkg::ACC_W-1:0];
            fill_in  = req_data.last_in ? '0 : p_rest_fill[svap_pkg::FILL_W-1:0];
         end
      end else begin
         work_data.cnt  = u_cnt;
         work_data.val0 = {1'b0, u_acc[6:0]};
         work_data.val1 = {1'b0, u_acc[13:7]};
         work_data.last = req_data.last_in;
         if (accept) begin
            if (req_data.last_in) begin
               accum_in = '0;
               fill_in  = '0;
               left_in  = count_ff;
            end else begin
               accum_in = u_rest[svap_pkg::ACC_W-1:0];
               fill_in  = u_rest_fill[svap_pkg::FILL_W-1:0];
               left_in  = left_ff - {30'd0, u_cnt};
            end
         end
      end

      if (csr_write) begin
         unique case (csr_index)
            svap_pkg::CSR_MODE: begin
               mode_in  = csr_wdata[0];
               accum_in = '0;
               fill_in  = '0;
            end
            svap_pkg::CSR_CHAR_COUNT: begin
               count_in = csr_wdata;
               left_in  = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign work_push = accept && (work_data.cnt != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= svap_pkg::MODE_PACK;
         count_ff   <= '0;
         left_ff    <= '0;
         accum_ff   <= '0;
         fill_ff    <= '0;
         aborted_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         count_ff   <= count_in;
         left_ff    <= left_in;
         accum_ff   <= accum_in;
         fill_ff    <= fill_in;
         aborted_ff <= aborted_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/svap_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svap_queue
// short first-in first-out queue of work records between front and back
// ----------------------------------------------------------------------------
module svap_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  svap_pkg::work_type       push_data,
   input  wire                      pop,
   output svap_pkg::work_type       head,
   output logic                     full,
   output logic                     empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   svap_pkg::work_type   store_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff,  count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: rtl/svap_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svap_back
// splits each work record into single results and holds them in the
// output register until the consumer takes them
// ----------------------------------------------------------------------------
module svap_back (
   input  wire                  clock,
   input  wire                  reset,
   input  svap_pkg::work_type   head,
   input  wire                  queue_empty,
   output logic                 queue_pop,
   output logic                 busy_split,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output svap_pkg::rsp_type    rsp_data
);

   logic                 valid_ff, valid_in;
   logic                 sel_ff,   sel_in;
   svap_pkg::rsp_type    out_ff,   out_in;
   logic                 load;
   logic                 at_end;

   // second result of a two-byte record is pending
   assign busy_split = sel_ff;
   assign at_end     = sel_ff || (head.cnt == 2'd1);
   assign load       = !queue_empty && (!valid_ff || rsp_pop);
   assign queue_pop  = load && at_end;

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      out_in   = out_ff;
      if (load) begin
         valid_in        = 1'b1;
         sel_in          = !at_end;
         out_in.data_out = sel_ff ? head.val1 : head.val0;
         out_in.last_out = head.last && at_end;
         out_in.error    = head.error;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

// File: bench/tb_seven_bit_ascii_pack_unpack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_seven_bit_ascii_pack_unpack
// self-checking bench for the seven-bit ascii pack/unpack block: directed
// streams in both modes, random streams under changing register settings,
// then a bad character that locks the block into its aborted state
// ----------------------------------------------------------------------------
module tb_seven_bit_ascii_pack_unpack;
   timeunit 1ns;
   timeprecision 1ps;

   // indexes with no register behind them, writes must be ignored
   localparam logic [svap_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [svap_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   // ------------------------------------------------------------------------
   // scoreboard: bit-level predictor plus the queue of results still owed
   // ------------------------------------------------------------------------
   class conversion_scoreboard;
      logic                 mode;
      logic [31:0]          char_count;
      logic [31:0]          chars_left;
      logic [15:0]          bit_accum;
      int unsigned          bit_fill;
      bit                   aborted;
      svap_pkg::rsp_type    owed_results[$];
      int unsigned          mismatches;
      int unsigned          bytes_in;
      int unsigned          results_seen;

      function new();
         mode         = svap_pkg::MODE_PACK;
         char_count   = '0;
         chars_left   = '0;
         bit_accum    = '0;
         bit_fill     = 0;
         aborted      = 1'b0;
         mismatches   = 0;
         bytes_in     = 0;
         results_seen = 0;
      endfunction

      // register write as seen by the block
      function void apply_write(logic [svap_pkg::CSR_INDEX_W-1:0] reg_index,
                                logic [31:0] value);
         case (reg_index)
            svap_pkg::CSR_MODE: begin
               mode      = value[0];
               bit_accum = '0;
               bit_fill  = 0;
            end
            svap_pkg::CSR_CHAR_COUNT: begin
               char_count = value;
               chars_left = value;
            end
            default: ;
         endcase
      endfunction

      // works out the results of one accepted input transfer
      function void predict_conversion(svap_pkg::req_type item);
         logic [7:0]          vals [2];
         int                  n;
         svap_pkg::rsp_type   r;
         n = 0;
         bytes_in++;
         // a pack-mode byte with the top bit set locks the block up for good
         if (aborted || (mode == svap_pkg::MODE_PACK && item.data_in[7])) begin
            aborted    = 1'b1;
            r.data_out = '0;
            r.last_out = 1'b1;
            r.error    = 1'b1;
            owed_results.push_back(r);
            return;
         end
         if (mode == svap_pkg::MODE_PACK) begin
            bit_accum = bit_accum | ({9'b0, item.data_in[6:0]} << bit_fill);
            bit_fill += 7;
            if (bit_fill >= 8) begin
               vals[n] = bit_accum[7:0];
               n++;
               bit_accum = bit_accum >> 8;
               bit_fill -= 8;
            end
            if (item.last_in) begin
               // flush leftover bits, zero padded at the top
               if (bit_fill > 0) begin
                  vals[n] = bit_accum[7:0];
                  n++;
               end
               bit_accum = '0;
               bit_fill  = 0;
            end
         end else begin
            bit_accum = bit_accum | ({8'b0, item.data_in} << bit_fill);
            bit_fill += 8;
            while (bit_fill >= 7) begin
               // groups past the character count are consumed silently
               if (chars_left != 0) begin
                  vals[n] = {1'b0, bit_accum[6:0]};
                  n++;
                  chars_left = chars_left - 1;
               end
               bit_accum = bit_accum >> 7;
               bit_fill -= 7;
            end
            if (item.last_in) begin
               bit_accum  = '0;
               bit_fill   = 0;
               chars_left = char_count;
            end
         end
         for (int k = 0; k < n; k++) begin
            r.data_out = vals[k];
            r.last_out = (k == n - 1) && item.last_in;
            r.error    = 1'b0;
            owed_results.push_back(r);
         end
      endfunction

      // compares one accepted result with the oldest one owed
      function void check_result(svap_pkg::rsp_type got);
         svap_pkg::rsp_type want;
         results_seen++;
         if (owed_results.size() == 0) begin
            $error("unexpected result: data_out=%h last_out=%b error=%b",
                   got.data_out, got.last_out, got.error);
            mismatches++;
            return;
         end
         want = owed_results.pop_front();
         if (got.data_out !== want.data_out) begin
            $error("data_out: expected %h, actual %h", want.data_out, got.data_out);
            mismatches++;
         end
         if (got.last_out !== want.last_out) begin
            $error("last_out: expected %b, actual %b", want.last_out, got.last_out);
            mismatches++;
         end
         if (got.error !== want.error) begin
            $error("error: expected %b, actual %b", want.error, got.error);
            mismatches++;
         end
      endfunction

      function void check_drained();
         if (owed_results.size() != 0) begin
            $error("%0d expected results never arrived", owed_results.size());
            mismatches++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // signals, every block input known from time zero
   // ------------------------------------------------------------------------
   logic                                 clock;
   logic                                 reset     = 1'b1;
   logic                                 req_push  = 1'b0;
   logic                                 req_full;
   svap_pkg::req_type                    req_data  = '0;
   logic                                 rsp_empty;
   logic                                 rsp_pop   = 1'b0;
   svap_pkg::rsp_type                    rsp_data;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [svap_pkg::CSR_INDEX_W-1:0]     csr_index = svap_pkg::CSR_MODE;
   logic [31:0]                          csr_wdata = '0;

   conversion_scoreboard board;
   bit          idling     = 1'b1;   // random gaps and stalls allowed
   int unsigned reg_writes = 0;

   seven_bit_ascii_pack_unpack DUT (
      .clock,
      .reset,
      .req_push,
      .req_full,
      .req_data,
      .rsp_empty,
      .rsp_pop,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_wdata
   );

   initial begin
      clock = 1'b0;
      forever #5ns clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin : watchdog
      #2ms;
      $error("run timed out");
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // result side: pop decided at the falling edge, transfer seen at the rising
   // ------------------------------------------------------------------------
   initial begin : result_consumer
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_pop = 1'b0;
            stall_left--;
         end else begin
            rsp_pop = 1'b1;
            // occasional stall burst while idling is set
            if (idling && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 11);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) board.check_result(rsp_data);
   end

   // ------------------------------------------------------------------------
   // drive tasks
   // ------------------------------------------------------------------------

   // sender gap: push low for a number of cycles
   task automatic hold_off(input int unsigned cycles);
      @(negedge clock);
      req_push = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // one input transfer, then maybe a random gap
   task automatic push_byte(input logic [7:0] data, input logic last);
      svap_pkg::req_type item;
      item.data_in = data;
      item.last_in = last;
      @(negedge clock);
      req_push = 1'b1;
      req_data = item;
      do @(posedge clock); while (req_full);
      board.predict_conversion(item);
      if (idling && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 11));
   endtask

   // stop sending until every owed result is out, then let the pipe empty
   task automatic wait_for_drain();
      @(negedge clock);
      req_push = 1'b0;
      while (board.owed_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [svap_pkg::CSR_INDEX_W-1:0] reg_index,
                            input logic [31:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = reg_index;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      board.apply_write(reg_index, value);
      reg_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // random stream: characters below 0x80 in pack mode, any byte in unpack
   task automatic send_stream(input int unsigned len, input bit terminate);
      logic [7:0] data;
      for (int unsigned i = 0; i < len; i++) begin
         data = (board.mode == svap_pkg::MODE_UNPACK) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 127));
         push_byte(data, terminate && (i == len - 1));
      end
   endtask

   // mostly short well-formed streams, some long, some cut off with no last
   task automatic random_streams(input int unsigned n_items);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         if (len > n_items - sent) len = n_items - sent;
         send_stream(len, $urandom_range(0, 11) != 0);
         sent += len;
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [31:0] count_val;
      logic        unpack;
      board = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // pack: extremes, a flush of leftover bits, eight characters filling
      // exactly seven bytes so the last transfer adds no flush byte
      write_reg(svap_pkg::CSR_MODE, 32'(svap_pkg::MODE_PACK));
      push_byte(8'h7F, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h2A, 1'b1);
      for (int i = 0; i < 8; i++) push_byte(8'h7F, i == 7);
      // partial stream left hanging, the mode write drops it
      push_byte(8'h33, 1'b0);
      wait_for_drain();

      // unpack: seven bytes hold eight groups, count of seven drops the pad
      write_reg(svap_pkg::CSR_MODE, 32'(svap_pkg::MODE_UNPACK));
      write_reg(svap_pkg::CSR_CHAR_COUNT, 32'd7);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'hAA, 1'b0);
      push_byte(8'h55, 1'b1);
      wait_for_drain();

      // count runs out mid-stream
      write_reg(svap_pkg::CSR_CHAR_COUNT, 32'd1);
      push_byte(8'hC3, 1'b0);
      push_byte(8'h3C, 1'b1);
      wait_for_drain();

      // zero count: the last transfer yields no result at all
      write_reg(svap_pkg::CSR_CHAR_COUNT, 32'd0);
      push_byte(8'hFF, 1'b1);
      wait_for_drain();

      // writes to unused indexes change nothing
      write_reg(CSR_SPARE_A, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE_B, 32'h5A5A_5A5A);

      // random phases alternating mode; final phase runs with no idling
      for (int p = 0; p < 8; p++) begin
         wait_for_drain();
         if (p == 7) idling = 1'b0;
         unpack = p[0];
         // junk in the upper bits of the mode write must be ignored
         write_reg(svap_pkg::CSR_MODE, ($urandom() & ~32'd1) | 32'(unpack));
         case (p)
            1:       count_val = 32'hFFFF_FFFF;
            3:       count_val = 32'd0;
            default: count_val = $urandom_range(0, 1) ? 32'($urandom_range(1, 24)) : $urandom();
         endcase
         if (unpack || $urandom_range(0, 1) == 1) begin
            write_reg(svap_pkg::CSR_CHAR_COUNT, count_val);
         end
         random_streams(75);
      end

      // abort: a bad character mid-stream, then noise in both modes
      wait_for_drain();
      write_reg(svap_pkg::CSR_MODE, 32'(svap_pkg::MODE_PACK));
      send_stream(5, 1'b0);
      push_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
      repeat (20) push_byte(8'($urandom()), 1'($urandom()));
      wait_for_drain();
      write_reg(svap_pkg::CSR_MODE, 32'(svap_pkg::MODE_UNPACK));
      repeat (10) push_byte(8'($urandom()), 1'($urandom()));

      // let stragglers show up before the final verdict
      wait_for_drain();
      repeat (10) @(posedge clock);
      board.check_drained();

      $display("summary: %0d bytes in, %0d results checked, %0d register writes",
               board.bytes_in, board.results_seen, reg_writes);
      $display("summary: pack and unpack streams, count limits, dropped partials, abort lock");
      if (board.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
